[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the record frame checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge outside reset
`define LRFC_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define LRFC_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define LRFC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[design/lrfc_pkg.sv]
// ----------------------------------------------------------------------------
// lrfc_pkg
// shared types, constants and crc helper for the log record frame checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lrfc_pkg;

   // width of the running good-end position counter
   localparam int unsigned POSITION_BITS = 32;
   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
   localparam int unsigned SUM_BITS = ((POSITION_BITS > 17) ? POSITION_BITS : 17) + 1;

   // byte index within a record
   localparam int unsigned IDX_BITS = 17;
   localparam logic [IDX_BITS-1:0] HEADER_LEN     = 17'd28;
   localparam logic [IDX_BITS-1:0] IDX_MAGIC_LAST = 17'd3;
   localparam logic [IDX_BITS-1:0] IDX_TYPE       = 17'd4;
   localparam logic [IDX_BITS-1:0] IDX_FLAGS      = 17'd5;
   localparam logic [IDX_BITS-1:0] IDX_LEN_LO     = 17'd6;
   localparam logic [IDX_BITS-1:0] IDX_LEN_HI     = 17'd7;
   localparam logic [IDX_BITS-1:0] IDX_SEQ_END    = 17'd16;
   localparam logic [IDX_BITS-1:0] IDX_TXN_END    = 17'd24;
   localparam logic [IDX_BITS-1:0] CRC_BYTES      = 17'd4;
   localparam logic [IDX_BITS-1:0] CRC_LAST_OFS   = 17'd3;

   localparam logic [31:0] MAGIC_DEFAULT = 32'h514C_5052;
   localparam logic [31:0] CRC_POLY      = 32'h82F6_3B78;
   localparam logic [31:0] CRC_ONES      = 32'hFFFF_FFFF;

   // result queue
   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned PTR_BITS   = $clog2(FIFO_DEPTH);
   localparam int unsigned CNT_BITS   = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_BAD_MAGIC   = 3'd1,
      ST_CRC_MISMATCH = 3'd2,
      ST_END_CLEAN   = 3'd3,
      ST_END_PARTIAL = 3'd4
   } status_type;

   typedef struct packed {
      status_type   status;
      logic [7:0]   record_type;
      logic [7:0]   record_flags;
      logic [15:0]  payload_length;
      logic [63:0]  sequence_number;
      logic [63:0]  transaction_id;
      logic [31:0]  good_end_position;
      logic [63:0]  highest_sequence;
      logic         last_of_run;
   } result_type;

   // results produced by one accepted item
   typedef struct packed {
      logic [1:0]   count;
      result_type   first;
      result_type   second;
   } push_type;

   // one byte of reflected crc32c, bit at a time
   function automatic logic [31:0] crc32c_byte(input logic [31:0] crc,
                                               input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
      end
      return c;
   endfunction

   // position as reported, clamped to 32 bits
   function automatic logic [31:0] clamp_position(input logic [POSITION_BITS-1:0] p);
      logic [POSITION_BITS-1:0] high_part;
      high_part = p >> 32;
      if (high_part != '0) begin
         return 32'hFFFF_FFFF;
      end
      return 32'(p);
   endfunction

endpackage

`default_nettype wire

[design/lrfc_parser.sv]
// ----------------------------------------------------------------------------
// lrfc_parser
// per-byte record state, crc32c check and result generation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lrfc_parser (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                item_accept,
   input  wire logic [7:0]          data_byte,
   input  wire logic                byte_present,
   input  wire logic                end_of_buffer,
   input  wire logic [31:0]         record_magic,
   output lrfc_pkg::push_type       push
);

   logic [lrfc_pkg::IDX_BITS-1:0]      bir_ff, bir_in;
   logic [31:0]                        magic_ff, magic_in;
   logic [7:0]                         type_ff, type_in;
   logic [7:0]                         flags_ff, flags_in;
   logic [15:0]                        length_ff, length_in;
   logic [63:0]                        seq_ff, seq_in;
   logic [63:0]                        trans_ff, trans_in;
   logic [31:0]                        crc_ff, crc_in;
   logic [31:0]                        stored_ff, stored_in;
   logic [lrfc_pkg::POSITION_BITS-1:0] good_end_ff, good_end_in;
   logic [63:0]                        max_seq_ff, max_seq_in;
   logic                               stopped_ff, stopped_in;

   logic                               take;
   logic                               item_end;
   logic [lrfc_pkg::IDX_BITS-1:0]      body;
   logic [lrfc_pkg::IDX_BITS-1:0]      size;
   logic [lrfc_pkg::SUM_BITS-1:0]      sum;
   logic [31:0]                        magic_next;
   logic [31:0]                        stored_next;
   logic                               byte_hit;
   lrfc_pkg::result_type               byte_res;
   lrfc_pkg::result_type               end_res;

   assign take     = item_accept && byte_present && !stopped_ff;
   assign item_end = item_accept && end_of_buffer;

   always_comb begin
      bir_in      = bir_ff;
      magic_in    = magic_ff;
      type_in     = type_ff;
      flags_in    = flags_ff;
      length_in   = length_ff;
      seq_in      = seq_ff;
      trans_in    = trans_ff;
      crc_in      = crc_ff;
      stored_in   = stored_ff;
      good_end_in = good_end_ff;
      max_seq_in  = max_seq_ff;
      stopped_in  = stopped_ff;
      byte_hit    = 1'b0;
      byte_res    = '0;
      end_res     = '0;
      push        = '0;

      body        = lrfc_pkg::HEADER_LEN + lrfc_pkg::IDX_BITS'(length_ff);
      size        = body + lrfc_pkg::CRC_BYTES;
      sum         = lrfc_pkg::SUM_BITS'(good_end_ff) + lrfc_pkg::SUM_BITS'(size);
      magic_next  = {data_byte, magic_ff[31:8]};
      stored_next = {data_byte, stored_ff[31:8]};

      if (take) begin
         if (bir_ff < body) begin
            crc_in = lrfc_pkg::crc32c_byte(crc_ff, data_byte);
         end
         bir_in = bir_ff + lrfc_pkg::IDX_BITS'(1);

         if (bir_ff < lrfc_pkg::IDX_TYPE) begin
            magic_in = magic_next;
            if (bir_ff == lrfc_pkg::IDX_MAGIC_LAST && magic_next != record_magic) begin
               byte_hit        = 1'b1;
               byte_res.status = lrfc_pkg::ST_BAD_MAGIC;
               stopped_in      = 1'b1;
               bir_in          = '0;
               crc_in          = lrfc_pkg::CRC_ONES;
               magic_in        = '0;
               stored_in       = '0;
            end
         end else if (bir_ff == lrfc_pkg::IDX_TYPE) begin
            type_in = data_byte;
         end else if (bir_ff == lrfc_pkg::IDX_FLAGS) begin
            flags_in = data_byte;
         end else if (bir_ff == lrfc_pkg::IDX_LEN_LO) begin
            length_in = {8'd0, data_byte};
         end else if (bir_ff == lrfc_pkg::IDX_LEN_HI) begin
            length_in = {data_byte, length_ff[7:0]};
         end else if (bir_ff < lrfc_pkg::IDX_SEQ_END) begin
            seq_in = {data_byte, seq_ff[63:8]};
         end else if (bir_ff < lrfc_pkg::IDX_TXN_END) begin
            trans_in = {data_byte, trans_ff[63:8]};
         end else if (bir_ff >= body) begin
            stored_in = stored_next;
            if (bir_ff == body + lrfc_pkg::CRC_LAST_OFS) begin
               byte_hit  = 1'b1;
               bir_in    = '0;
               crc_in    = lrfc_pkg::CRC_ONES;
               magic_in  = '0;
               stored_in = '0;
               if (stored_next != ~crc_ff) begin
                  byte_res.status = lrfc_pkg::ST_CRC_MISMATCH;
                  stopped_in      = 1'b1;
               end else begin
                  // saturating advance of the good end
                  if (sum > lrfc_pkg::SUM_BITS'(lrfc_pkg::POS_MAX)) begin
                     good_end_in = lrfc_pkg::POS_MAX;
                  end else begin
                     good_end_in = lrfc_pkg::POSITION_BITS'(sum);
                  end
                  if (seq_ff > max_seq_ff) begin
                     max_seq_in = seq_ff;
                  end
                  byte_res.status          = lrfc_pkg::ST_OK;
                  byte_res.record_type     = type_ff;
                  byte_res.record_flags    = flags_ff;
                  byte_res.payload_length  = length_ff;
                  byte_res.sequence_number = seq_ff;
                  byte_res.transaction_id  = trans_ff;
               end
            end
         end
      end

      byte_res.good_end_position = lrfc_pkg::clamp_position(good_end_in);
      byte_res.highest_sequence  = max_seq_in;

      end_res.status = (stopped_in || bir_in != '0) ? lrfc_pkg::ST_END_PARTIAL
                                                    : lrfc_pkg::ST_END_CLEAN;
      end_res.good_end_position = lrfc_pkg::clamp_position(good_end_in);
      end_res.highest_sequence  = max_seq_in;
      end_res.last_of_run       = 1'b1;

      if (byte_hit && item_end) begin
         push.count  = 2'd2;
         push.first  = byte_res;
         push.second = end_res;
      end else if (byte_hit) begin
         push.count             = 2'd1;
         push.first             = byte_res;
         push.first.last_of_run = 1'b1;
      end else if (item_end) begin
         push.count = 2'd1;
         push.first = end_res;
      end

      // end of buffer clears all parser state, the magic shift register included
      if (item_end) begin
         bir_in      = '0;
         magic_in    = '0;
         type_in     = '0;
         flags_in    = '0;
         length_in   = '0;
         seq_in      = '0;
         trans_in    = '0;
         crc_in      = lrfc_pkg::CRC_ONES;
         stored_in   = '0;
         good_end_in = '0;
         max_seq_in  = '0;
         stopped_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bir_ff      <= '0;
         magic_ff    <= '0;
         type_ff     <= '0;
         flags_ff    <= '0;
         length_ff   <= '0;
         seq_ff      <= '0;
         trans_ff    <= '0;
         crc_ff      <= lrfc_pkg::CRC_ONES;
         stored_ff   <= '0;
         good_end_ff <= '0;
         max_seq_ff  <= '0;
         stopped_ff  <= 1'b0;
      end else if (item_accept) begin
         bir_ff      <= bir_in;
         magic_ff    <= magic_in;
         type_ff     <= type_in;
         flags_ff    <= flags_in;
         length_ff   <= length_in;
         seq_ff      <= seq_in;
         trans_ff    <= trans_in;
         crc_ff      <= crc_in;
         stored_ff   <= stored_in;
         good_end_ff <= good_end_in;
         max_seq_ff  <= max_seq_in;
         stopped_ff  <= stopped_in;
      end
   end

   // a pair of results is always a record result followed by the end result
   `LRFC_ASSERT_IMPLIES(a_pair_order, clock, reset, push.count == 2'd2,
      push.second.last_of_run && !push.first.last_of_run &&
      (push.second.status == lrfc_pkg::ST_END_CLEAN ||
       push.second.status == lrfc_pkg::ST_END_PARTIAL))
   // once stopped, only an end of buffer releases the block
   `LRFC_ASSERT_NEXT(a_stop_holds, clock, reset, stopped_ff && !item_end, stopped_ff)

endmodule

`default_nettype wire

[design/lrfc_out_fifo.sv]
// ----------------------------------------------------------------------------
// lrfc_out_fifo
// small result queue, up to two in and one out (when out_ready) per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lrfc_out_fifo (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lrfc_pkg::push_type   push,
   output logic                      room_for_two,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output lrfc_pkg::result_type      out_head
);

   lrfc_pkg::result_type               entries_ff [lrfc_pkg::FIFO_DEPTH];
   logic [lrfc_pkg::PTR_BITS-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [lrfc_pkg::PTR_BITS-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [lrfc_pkg::CNT_BITS-1:0]      count_ff, count_in;
   logic [lrfc_pkg::PTR_BITS-1:0]      wr_next;
   logic                               pop;

   assign out_valid    = (count_ff != '0);
   assign out_head     = entries_ff[rd_ptr_ff];
   assign pop          = out_valid && out_ready;
   assign room_for_two = (count_ff <= lrfc_pkg::CNT_BITS'(lrfc_pkg::FIFO_DEPTH - 2));
   assign wr_next      = wr_ptr_ff + lrfc_pkg::PTR_BITS'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + lrfc_pkg::PTR_BITS'(push.count);
      rd_ptr_in = rd_ptr_ff + lrfc_pkg::PTR_BITS'(pop);
      count_in  = count_ff + lrfc_pkg::CNT_BITS'(push.count)
                  - lrfc_pkg::CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entries_ff[wr_next] <= push.second;
      end
   end

   `LRFC_ASSERT_ALWAYS(a_count_bound, clock, reset,
      count_ff <= lrfc_pkg::CNT_BITS'(lrfc_pkg::FIFO_DEPTH))
   // the producer only pushes while two entries are free
   `LRFC_ASSERT_IMPLIES(a_no_overflow, clock, reset, push.count != 2'd0, room_for_two)

endmodule

`default_nettype wire

[design/log_record_frame_checker_unit.sv]
// ----------------------------------------------------------------------------
// log_record_frame_checker_unit
// byte-serial deframer for crc32c-protected log records
// ----------------------------------------------------------------------------
//
//   channel | prefix | direction | moves per transfer
//   --------+--------+-----------+--------------------------------------------
//   request | req_   | in        | one buffer byte and/or the end-of-buffer mark
//   response| rsp_   | out       | one record, error or end-of-buffer result
//   csr     | csr_   | in        | new value of the expected record magic
//
// one request transfer per clock while req_ready is high; its results enter the
// response queue on the same edge and are visible from the next cycle
// an item that closes a record and ends the buffer gives two results, which
// leave one at a time through the four-entry response queue
// req_ready is low only while fewer than two queue entries are free
// reset is synchronous; it clears all record state and loads the default magic
// csr transfers are taken in every cycle and apply to the next request
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module log_record_frame_checker_unit (
   input  wire logic         clock,
   input  wire logic         reset,

   // configuration write channel
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [31:0]  csr_wdata,

   // request channel
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [7:0]   req_data_byte,
   input  wire logic         req_byte_present,
   input  wire logic         req_end_of_buffer,

   // response channel
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [2:0]        rsp_status,
   output logic [7:0]        rsp_record_type,
   output logic [7:0]        rsp_record_flags,
   output logic [15:0]       rsp_payload_length,
   output logic [63:0]       rsp_sequence_number,
   output logic [63:0]       rsp_transaction_id,
   output logic [31:0]       rsp_good_end_position,
   output logic [63:0]       rsp_highest_sequence,
   output logic              rsp_last_of_run
);

   // expected magic word, little-endian as it arrives on the wire
   logic [31:0]             magic_reg_ff;
   logic                    req_transfer;
   logic                    room_for_two;
   lrfc_pkg::push_type      push;
   lrfc_pkg::result_type    head;

   // csr writes never stall
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_reg_ff <= lrfc_pkg::MAGIC_DEFAULT;
      end else if (csr_valid && csr_ready) begin
         magic_reg_ff <= csr_wdata;
      end
   end

   // accept whenever the queue can hold the worst case of two results
   assign req_ready    = room_for_two;
   assign req_transfer = req_valid && req_ready;

   // record parsing, crc check and result formation
   lrfc_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .item_accept   (req_transfer),
      .data_byte     (req_data_byte),
      .byte_present  (req_byte_present),
      .end_of_buffer (req_end_of_buffer),
      .record_magic  (magic_reg_ff),
      .push          (push)
   );

   // response queue decouples the request side from response stalls
   lrfc_out_fifo u_out_fifo (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .room_for_two (room_for_two),
      .out_valid    (rsp_valid),
      .out_ready    (rsp_ready),
      .out_head     (head)
   );

   // unpack the queue head onto the response ports
   assign rsp_status            = head.status;
   assign rsp_record_type       = head.record_type;
   assign rsp_record_flags      = head.record_flags;
   assign rsp_payload_length    = head.payload_length;
   assign rsp_sequence_number   = head.sequence_number;
   assign rsp_transaction_id    = head.transaction_id;
   assign rsp_good_end_position = head.good_end_position;
   assign rsp_highest_sequence  = head.highest_sequence;
   assign rsp_last_of_run       = head.last_of_run;

endmodule

`default_nettype wire
